// ===== src/cvd_pkg.sv =====
package cvd_pkg;

	localparam int ANGLE_ITERATIONS = 24;
	localparam int ITER = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;
	localparam int ROOT_STEPS = 32;
	localparam int NORM_STEPS = 6;
	localparam int REDUCE_STEPS = 3;

	localparam int VW = 45;
	localparam int ZW = 34;
	localparam int BW = 37;
	localparam int SW = 34;

	localparam logic signed [BW-1:0] Q30_PI = 37'sd3373259426;
	localparam logic signed [BW-1:0] Q30_HALF_PI = 37'sd1686629713;
	localparam logic signed [BW-1:0] Q30_TWO_PI = 37'sd6746518852;
	localparam logic signed [SW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

	typedef enum logic [2:0] {
		REG_SPINE_HORIZONTAL,
		REG_SPINE_POSITION,
		REG_APEX_ALONG,
		REG_SINE_CONE_ANGLE,
		REG_COSINE_CONE_ANGLE,
		REG_INVERSE_SINE_CONE,
		REG_SINE_ROTATION,
		REG_COSINE_ROTATION
	} cfg_index_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
	} result_t;

	typedef struct packed {
		logic               spine_horizontal;
		logic signed [31:0] spine_position;
		logic signed [31:0] apex_along;
		logic [30:0]        sine_cone_angle;
		logic [30:0]        cosine_cone_angle;
		logic [30:0]        inverse_sine_cone;
		logic signed [31:0] sine_rotation;
		logic signed [31:0] cosine_rotation;
	} cfg_t;

	typedef struct packed {
		logic        nz;
		logic [31:0] r;
		vertex_t     vtx;
	} side_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] u;
		logic [31:0]        adx;
		logic [31:0]        ady;
		vertex_t            vtx;
	} front_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] u;
		logic [31:0]        ady;
		side_t              side;
	} root_out_t;

	typedef struct packed {
		logic                 valid;
		logic signed [SW-1:0] sb;
		logic signed [SW-1:0] cb;
		side_t                side;
	} angle_out_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		if (v > 72'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -72'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [71:0] rnd30(input logic signed [71:0] p);
		return (p + 72'sd536870912) >>> 30;
	endfunction

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		unique case (i)
			5'd0:  a = 32'h3243F6A8;
			5'd1:  a = 32'h1DAC6705;
			5'd2:  a = 32'h0FADBAFC;
			5'd3:  a = 32'h07F56EA6;
			5'd4:  a = 32'h03FEAB76;
			5'd5:  a = 32'h01FFD55B;
			5'd6:  a = 32'h00FFFAAA;
			5'd7:  a = 32'h007FFF55;
			5'd8:  a = 32'h003FFFEA;
			5'd9:  a = 32'h001FFFFD;
			5'd10: a = 32'h000FFFFF;
			5'd11: a = 32'h0007FFFF;
			5'd12: a = 32'h0003FFFF;
			5'd13: a = 32'h0001FFFF;
			5'd14: a = 32'h0000FFFF;
			5'd15: a = 32'h00007FFF;
			5'd16: a = 32'h00003FFF;
			5'd17: a = 32'h00001FFF;
			5'd18: a = 32'h00000FFF;
			5'd19: a = 32'h000007FF;
			5'd20: a = 32'h000003FF;
			5'd21: a = 32'h000001FF;
			5'd22: a = 32'h000000FF;
			5'd23: a = 32'h0000007F;
			5'd24: a = 32'h0000003F;
			5'd25: a = 32'h0000001F;
			5'd26: a = 32'h0000000F;
			5'd27: a = 32'h00000008;
			5'd28: a = 32'h00000004;
			5'd29: a = 32'h00000002;
			5'd30: a = 32'h00000001;
			5'd31: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

// ===== src/cone_curl_vertex_deform.sv =====
// Cone page-curl vertex deformer. One flat vertex is taken on every cycle in
// which start is high (busy stays low), and its deformed position appears on
// result with result_valid high for exactly one cycle, in order. The pipeline
// runs through the 32-step square-root chain and the two CORDIC chains;
// throughput is one vertex per cycle. The receiver cannot stall, so results
// must be captured when result_valid is high. Write the cone and rotation
// registers only while no vertex is in flight.
module cone_curl_vertex_deform import cvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  vertex_t    vertex,
	output logic       result_valid,
	output result_t    result,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spine_horizontal <= 1'b0;
			cfg_q.spine_position <= '0;
			cfg_q.apex_along <= '0;
			cfg_q.sine_cone_angle <= 31'd1073741824;
			cfg_q.cosine_cone_angle <= '0;
			cfg_q.inverse_sine_cone <= 31'd268435456;
			cfg_q.sine_rotation <= '0;
			cfg_q.cosine_rotation <= 32'sd1073741824;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPINE_HORIZONTAL:  cfg_q.spine_horizontal <= cfg_data[0];
				REG_SPINE_POSITION:    cfg_q.spine_position <= $signed(cfg_data);
				REG_APEX_ALONG:        cfg_q.apex_along <= $signed(cfg_data);
				REG_SINE_CONE_ANGLE:   cfg_q.sine_cone_angle <= cfg_data[30:0];
				REG_COSINE_CONE_ANGLE: cfg_q.cosine_cone_angle <= cfg_data[30:0];
				REG_INVERSE_SINE_CONE: cfg_q.inverse_sine_cone <= cfg_data[30:0];
				REG_SINE_ROTATION:     cfg_q.sine_rotation <= $signed(cfg_data);
				REG_COSINE_ROTATION:   cfg_q.cosine_rotation <= $signed(cfg_data);
			endcase
		end
	end

	assign busy = 1'b0;

	logic signed [31:0] sel;
	logic signed [31:0] along;
	logic signed [31:0] u;
	logic signed [31:0] dy;

	always_comb begin
		sel = cfg_q.spine_horizontal ? vertex.vertex_y : vertex.vertex_x;
		along = cfg_q.spine_horizontal ? vertex.vertex_x : vertex.vertex_y;
		u = sat32(72'(sel) - 72'(cfg_q.spine_position));
		dy = sat32(72'(along) - 72'(cfg_q.apex_along));
	end

	front_t front_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1 <= '0;
		end else begin
			front_s1.valid <= start && !busy;
			front_s1.u <= u;
			front_s1.adx <= u[31] ? (~$unsigned(u) + 32'd1) : $unsigned(u);
			front_s1.ady <= dy[31] ? (~$unsigned(dy) + 32'd1) : $unsigned(dy);
			front_s1.vtx <= vertex;
		end
	end

	root_out_t  root;
	angle_out_t angle;

	cvd_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front_s1),
		.root   (root)
	);

	cvd_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.root   (root),
		.angle  (angle)
	);

	cvd_project u_project (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.angle        (angle),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== src/cvd_root.sv =====
module cvd_root import cvd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  front_t    front,
	output root_out_t root
);

	logic        valid_s1;
	logic [63:0] sqa_s1;
	logic [63:0] sqb_s1;
	logic signed [31:0] u_s1;
	logic [31:0] ady_s1;
	logic        nz_s1;
	vertex_t     vtx_s1;

	logic        valid_s [ROOT_STEPS+1];
	logic [63:0] n_s     [ROOT_STEPS+1];
	logic [63:0] res_s   [ROOT_STEPS+1];
	logic signed [31:0] u_s [ROOT_STEPS+1];
	logic [31:0] ady_s   [ROOT_STEPS+1];
	logic        nz_s    [ROOT_STEPS+1];
	vertex_t     vtx_s   [ROOT_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s[0] <= 1'b0;
		end else begin
			valid_s1 <= front.valid;
			valid_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqa_s1 <= 64'(front.adx) * 64'(front.adx);
		sqb_s1 <= 64'(front.ady) * 64'(front.ady);
		u_s1 <= front.u;
		ady_s1 <= front.ady;
		nz_s1 <= |{front.adx, front.ady};
		vtx_s1 <= front.vtx;
		n_s[0] <= sqa_s1 + sqb_s1;
		res_s[0] <= 64'd0;
		u_s[0] <= u_s1;
		ady_s[0] <= ady_s1;
		nz_s[0] <= nz_s1;
		vtx_s[0] <= vtx_s1;
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;

		assign trial = res_s[k] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[k+1] <= 1'b0;
			else
				valid_s[k+1] <= valid_s[k];
		end

		always_ff @(posedge clk) begin
			if (n_s[k] >= trial) begin
				n_s[k+1] <= n_s[k] - trial;
				res_s[k+1] <= (res_s[k] >> 1) + BIT;
			end else begin
				n_s[k+1] <= n_s[k];
				res_s[k+1] <= res_s[k] >> 1;
			end
			u_s[k+1] <= u_s[k];
			ady_s[k+1] <= ady_s[k];
			nz_s[k+1] <= nz_s[k];
			vtx_s[k+1] <= vtx_s[k];
		end
	end

	always_comb begin
		root.valid = valid_s[ROOT_STEPS];
		root.u = u_s[ROOT_STEPS];
		root.ady = ady_s[ROOT_STEPS];
		root.side.nz = nz_s[ROOT_STEPS];
		root.side.r = res_s[ROOT_STEPS][31:0];
		root.side.vtx = vtx_s[ROOT_STEPS];
	end

	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[ROOT_STEPS] |-> res_s[ROOT_STEPS][63:32] == 32'd0)
		else $error("root exceeds 32 bits");

endmodule

// ===== src/cvd_angle.sv =====
module cvd_angle import cvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  root_out_t  root,
	output angle_out_t angle
);

	logic [31:0] au;
	assign au = root.u[31] ? (~$unsigned(root.u) + 32'd1) : $unsigned(root.u);

	// normalize
	logic                 nv_s [NORM_STEPS+1];
	logic [40:0]          nm_s [NORM_STEPS+1];
	logic signed [VW-1:0] nx_s [NORM_STEPS+1];
	logic signed [VW-1:0] ny_s [NORM_STEPS+1];
	side_t                nd_s [NORM_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			nv_s[0] <= 1'b0;
		else
			nv_s[0] <= root.valid;
	end

	always_ff @(posedge clk) begin
		nm_s[0] <= 41'((root.ady > au) ? root.ady : au);
		nx_s[0] <= VW'($signed({1'b0, root.ady}));
		ny_s[0] <= VW'(root.u);
		nd_s[0] <= root.side;
	end

	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		localparam int SH = 32 >> j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				nv_s[j+1] <= 1'b0;
			else
				nv_s[j+1] <= nv_s[j];
		end

		always_ff @(posedge clk) begin
			if (nm_s[j][40 -: SH] == '0) begin
				nm_s[j+1] <= nm_s[j] << SH;
				nx_s[j+1] <= nx_s[j] <<< SH;
				ny_s[j+1] <= ny_s[j] <<< SH;
			end else begin
				nm_s[j+1] <= nm_s[j];
				nx_s[j+1] <= nx_s[j];
				ny_s[j+1] <= ny_s[j];
			end
			nd_s[j+1] <= nd_s[j];
		end
	end

	// vectoring
	logic                 av_s [ITER+1];
	logic signed [VW-1:0] ax_s [ITER+1];
	logic signed [VW-1:0] ay_s [ITER+1];
	logic signed [ZW-1:0] az_s [ITER+1];
	side_t                ad_s [ITER+1];

	always_comb begin
		av_s[0] = nv_s[NORM_STEPS];
		ax_s[0] = nx_s[NORM_STEPS];
		ay_s[0] = ny_s[NORM_STEPS];
		az_s[0] = '0;
		ad_s[0] = nd_s[NORM_STEPS];
	end

	for (genvar i = 0; i < ITER; i++) begin : g_atan
		localparam logic signed [ZW-1:0] ATAN = ZW'($signed({1'b0, atan_q30(5'(i))}));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				av_s[i+1] <= 1'b0;
			else
				av_s[i+1] <= av_s[i];
		end

		always_ff @(posedge clk) begin
			if (!ay_s[i][VW-1]) begin
				ax_s[i+1] <= ax_s[i] + (ay_s[i] >>> i);
				ay_s[i+1] <= ay_s[i] - (ax_s[i] >>> i);
				az_s[i+1] <= az_s[i] + ATAN;
			end else begin
				ax_s[i+1] <= ax_s[i] - (ay_s[i] >>> i);
				ay_s[i+1] <= ay_s[i] + (ax_s[i] >>> i);
				az_s[i+1] <= az_s[i] - ATAN;
			end
			ad_s[i+1] <= ad_s[i];
		end
	end

	// scale by 1/sin(theta), reduce and fold
	logic                 mv_s1;
	logic signed [65:0]   mp_s1;
	side_t                md_s1;
	logic                 rv_s [REDUCE_STEPS+1];
	logic signed [BW-1:0] rb_s [REDUCE_STEPS+1];
	side_t                rd_s [REDUCE_STEPS+1];
	logic                 fv_s1;
	logic signed [BW-1:0] fb_s1;
	logic                 fneg_s1;
	side_t                fd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
			rv_s[0] <= 1'b0;
			fv_s1 <= 1'b0;
		end else begin
			mv_s1 <= av_s[ITER];
			rv_s[0] <= mv_s1;
			fv_s1 <= rv_s[REDUCE_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		mp_s1 <= 66'(az_s[ITER]) * 66'($signed({1'b0, cfg.inverse_sine_cone}));
		md_s1 <= ad_s[ITER];
		rb_s[0] <= BW'((72'(mp_s1) + 72'sd134217728) >>> 28);
		rd_s[0] <= md_s1;
		if (rb_s[REDUCE_STEPS] > Q30_HALF_PI) begin
			fb_s1 <= rb_s[REDUCE_STEPS] - Q30_PI;
			fneg_s1 <= 1'b1;
		end else if (rb_s[REDUCE_STEPS] < -Q30_HALF_PI) begin
			fb_s1 <= rb_s[REDUCE_STEPS] + Q30_PI;
			fneg_s1 <= 1'b1;
		end else begin
			fb_s1 <= rb_s[REDUCE_STEPS];
			fneg_s1 <= 1'b0;
		end
		fd_s1 <= rd_s[REDUCE_STEPS];
	end

	for (genvar j = 0; j < REDUCE_STEPS; j++) begin : g_reduce
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rv_s[j+1] <= 1'b0;
			else
				rv_s[j+1] <= rv_s[j];
		end

		always_ff @(posedge clk) begin
			if (rb_s[j] > Q30_PI)
				rb_s[j+1] <= rb_s[j] - Q30_TWO_PI;
			else if (rb_s[j] < -Q30_PI)
				rb_s[j+1] <= rb_s[j] + Q30_TWO_PI;
			else
				rb_s[j+1] <= rb_s[j];
			rd_s[j+1] <= rd_s[j];
		end
	end

	// rotation
	logic                 sv_s   [ITER+1];
	logic signed [SW-1:0] sx_s   [ITER+1];
	logic signed [SW-1:0] sy_s   [ITER+1];
	logic signed [BW-1:0] sz_s   [ITER+1];
	logic                 sneg_s [ITER+1];
	side_t                sd_s   [ITER+1];

	always_comb begin
		sv_s[0] = fv_s1;
		sx_s[0] = CORDIC_GAIN;
		sy_s[0] = '0;
		sz_s[0] = fb_s1;
		sneg_s[0] = fneg_s1;
		sd_s[0] = fd_s1;
	end

	for (genvar i = 0; i < ITER; i++) begin : g_sincos
		localparam logic signed [BW-1:0] ATAN = BW'($signed({1'b0, atan_q30(5'(i))}));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sv_s[i+1] <= 1'b0;
			else
				sv_s[i+1] <= sv_s[i];
		end

		always_ff @(posedge clk) begin
			if (!sz_s[i][BW-1]) begin
				sx_s[i+1] <= sx_s[i] - (sy_s[i] >>> i);
				sy_s[i+1] <= sy_s[i] + (sx_s[i] >>> i);
				sz_s[i+1] <= sz_s[i] - ATAN;
			end else begin
				sx_s[i+1] <= sx_s[i] + (sy_s[i] >>> i);
				sy_s[i+1] <= sy_s[i] - (sx_s[i] >>> i);
				sz_s[i+1] <= sz_s[i] + ATAN;
			end
			sneg_s[i+1] <= sneg_s[i];
			sd_s[i+1] <= sd_s[i];
		end
	end

	logic                 ov_s1;
	logic signed [SW-1:0] osb_s1;
	logic signed [SW-1:0] ocb_s1;
	side_t                od_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_s1 <= 1'b0;
		else
			ov_s1 <= sv_s[ITER];
	end

	always_ff @(posedge clk) begin
		osb_s1 <= sneg_s[ITER] ? -sy_s[ITER] : sy_s[ITER];
		ocb_s1 <= sneg_s[ITER] ? -sx_s[ITER] : sx_s[ITER];
		od_s1 <= sd_s[ITER];
	end

	always_comb begin
		angle.valid = ov_s1;
		angle.sb = osb_s1;
		angle.cb = ocb_s1;
		angle.side = od_s1;
	end

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s[REDUCE_STEPS] |-> (rb_s[REDUCE_STEPS] <= Q30_PI) &&
			(rb_s[REDUCE_STEPS] >= -Q30_PI))
		else $error("angle not reduced into half turn");

	a_folded: assert property (@(posedge clk) disable iff (!arst_n)
		fv_s1 |-> (fb_s1 <= Q30_HALF_PI) && (fb_s1 >= -Q30_HALF_PI))
		else $error("angle not folded into quarter turn");

endmodule

// ===== src/cvd_project.sv =====
module cvd_project import cvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  angle_out_t angle,
	output logic       result_valid,
	output result_t    result
);

	logic signed [31:0] sinc;
	logic signed [31:0] cosc;
	assign sinc = $signed({1'b0, cfg.sine_cone_angle});
	assign cosc = $signed({1'b0, cfg.cosine_cone_angle});

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic valid_s9;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;

	logic signed [64:0]   pr_s1;
	logic signed [SW-1:0] sb_s1, cb_s1, sb_s2, cb_s2;
	logic signed [31:0]   r_s2;
	logic signed [65:0]   px1_s3;
	logic signed [66:0]   pt_s3;
	logic signed [31:0]   x1_s4, t_s4, x1_s5, x1_s6, z1_s6, y1_s6, y1_s7, y1_s8, x2_s8;
	logic signed [63:0]   py_s5, pz_s5, pa_s7, pb_s7;
	result_t              res_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s1 <= angle.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	logic signed [31:0] spx;
	assign spx = sat32(72'(cfg.spine_position) + 72'(x2_s8));

	always_ff @(posedge clk) begin
		pr_s1 <= 65'($signed({1'b0, angle.side.r})) * 65'(sinc);
		sb_s1 <= angle.sb;
		cb_s1 <= angle.cb;
		side_s1 <= angle.side;

		r_s2 <= sat32(rnd30(72'(pr_s1)));
		sb_s2 <= sb_s1;
		cb_s2 <= cb_s1;
		side_s2 <= side_s1;

		px1_s3 <= 66'(r_s2) * 66'(sb_s2);
		pt_s3 <= 67'(r_s2) * (67'sd1073741824 - 67'(cb_s2));
		side_s3 <= side_s2;

		x1_s4 <= sat32(rnd30(72'(px1_s3)));
		t_s4 <= sat32(rnd30(72'(pt_s3)));
		side_s4 <= side_s3;

		py_s5 <= 64'(t_s4) * 64'(sinc);
		pz_s5 <= 64'(t_s4) * 64'(cosc);
		x1_s5 <= x1_s4;
		side_s5 <= side_s4;

		y1_s6 <= sat32(72'($signed({1'b0, side_s5.r})) + 72'(cfg.apex_along) -
			rnd30(72'(py_s5)));
		z1_s6 <= sat32(rnd30(72'(pz_s5)));
		x1_s6 <= x1_s5;
		side_s6 <= side_s5;

		pa_s7 <= 64'(x1_s6) * 64'(cfg.cosine_rotation);
		pb_s7 <= 64'(z1_s6) * 64'(cfg.sine_rotation);
		y1_s7 <= y1_s6;
		side_s7 <= side_s6;

		x2_s8 <= sat32(72'(sat32(rnd30(72'(pa_s7)))) - 72'(sat32(rnd30(72'(pb_s7)))));
		y1_s8 <= y1_s7;
		side_s8 <= side_s7;

		if (!side_s8.nz) begin
			res_s9.out_x <= side_s8.vtx.vertex_x;
			res_s9.out_y <= side_s8.vtx.vertex_y;
		end else if (cfg.spine_horizontal) begin
			res_s9.out_x <= y1_s8;
			res_s9.out_y <= spx;
		end else begin
			res_s9.out_x <= spx;
			res_s9.out_y <= y1_s8;
		end
	end

	assign result_valid = valid_s9;
	assign result = res_s9;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s9 |-> $past(angle.valid, 9))
		else $error("result without matching item");

endmodule

// ===== tb/sv/tb_cone_curl_vertex_deform.sv =====
module tb_cone_curl_vertex_deform;
	import cvd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 58 + 2 * ITER;

	typedef longint signed s64_t;

	localparam s64_t ONE30 = 64'sd1073741824;
	localparam s64_t PI30 = 64'sd3373259426;
	localparam s64_t HALF_PI30 = 64'sd1686629713;
	localparam s64_t TWO_PI30 = 64'sd6746518852;
	localparam s64_t GAIN30 = 64'sh26DD3B6A;

	class deform_scoreboard;
		result_t expected_q[$];
		int errors;
		int checked;

		cfg_t regs;

		function void reset_regs();
			regs.spine_horizontal = 1'b0;
			regs.spine_position = '0;
			regs.apex_along = '0;
			regs.sine_cone_angle = 31'd1073741824;
			regs.cosine_cone_angle = '0;
			regs.inverse_sine_cone = 31'd268435456;
			regs.sine_rotation = '0;
			regs.cosine_rotation = 32'sd1073741824;
		endfunction

		function void write_reg(cfg_index_t idx, logic [31:0] d);
			case (idx)
				REG_SPINE_HORIZONTAL: regs.spine_horizontal = d[0];
				REG_SPINE_POSITION: regs.spine_position = d;
				REG_APEX_ALONG: regs.apex_along = d;
				REG_SINE_CONE_ANGLE: regs.sine_cone_angle = d[30:0];
				REG_COSINE_CONE_ANGLE: regs.cosine_cone_angle = d[30:0];
				REG_INVERSE_SINE_CONE: regs.inverse_sine_cone = d[30:0];
				REG_SINE_ROTATION: regs.sine_rotation = d;
				REG_COSINE_ROTATION: regs.cosine_rotation = d;
				default: ;
			endcase
		endfunction

		function s64_t clamp32(s64_t v);
			if (v > 64'sd2147483647)
				return 64'sd2147483647;
			if (v < -64'sd2147483648)
				return -64'sd2147483648;
			return v;
		endfunction

		function s64_t round_mul(s64_t a, s64_t b, int s);
			s64_t p;
			p = a * b + (64'sd1 <<< (s - 1));
			return p >>> s;
		endfunction

		function s64_t arctan_entry(int i);
			return s64_t'(atan_table(i));
		endfunction

		function logic [31:0] atan_table(int i);
			logic [31:0] t[32] = '{
				32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
				32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
				32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
				32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
				32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
				32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
				32'h00000001, 32'h00000000};
			return t[i];
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res;
			longint unsigned bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else
					res = res >> 1;
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function s64_t vector_angle(s64_t y, s64_t x);
			s64_t ay, m, z, nx, ny;
			ay = (y < 0) ? -y : y;
			m = (x > ay) ? x : ay;
			z = 0;
			while (m < (64'sd1 <<< 40)) begin
				x = x * 2;
				y = y * 2;
				m = m * 2;
			end
			for (int i = 0; i < ITER; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z = z + arctan_entry(i);
				end else begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z = z - arctan_entry(i);
				end
				x = nx;
				y = ny;
			end
			return z;
		endfunction

		function void rotate_unit(s64_t b, output s64_t sn, output s64_t cs);
			s64_t x, y, nx, ny;
			bit neg;
			x = GAIN30;
			y = 0;
			neg = 0;
			while (b > PI30)
				b = b - TWO_PI30;
			while (b < -PI30)
				b = b + TWO_PI30;
			if (b > HALF_PI30) begin
				b = b - PI30;
				neg = 1;
			end else if (b < -HALF_PI30) begin
				b = b + PI30;
				neg = 1;
			end
			for (int i = 0; i < ITER; i++) begin
				if (b >= 0) begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					b = b - arctan_entry(i);
				end else begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					b = b + arctan_entry(i);
				end
				x = nx;
				y = ny;
			end
			sn = neg ? -y : y;
			cs = neg ? -x : x;
		endfunction

		function result_t deform(vertex_t vin);
			s64_t bx, by, u, v, dy, adx, ady, rad, alpha, beta, sb, cb;
			s64_t r, x1, t, y1, z1, x2, sp, ap, sc, cc, isc, sr, cr;
			longint unsigned sum;
			result_t res;
			bx = s64_t'(vin.vertex_x);
			by = s64_t'(vin.vertex_y);
			sp = s64_t'(regs.spine_position);
			ap = s64_t'(regs.apex_along);
			sc = s64_t'({1'b0, regs.sine_cone_angle});
			cc = s64_t'({1'b0, regs.cosine_cone_angle});
			isc = s64_t'({1'b0, regs.inverse_sine_cone});
			sr = s64_t'(regs.sine_rotation);
			cr = s64_t'(regs.cosine_rotation);
			res.out_x = vin.vertex_x;
			res.out_y = vin.vertex_y;
			u = clamp32((regs.spine_horizontal ? by : bx) - sp);
			v = regs.spine_horizontal ? bx : by;
			dy = clamp32(v - ap);
			adx = (u < 0) ? -u : u;
			ady = (dy < 0) ? -dy : dy;
			sum = longint'(adx) * longint'(adx) + longint'(ady) * longint'(ady);
			rad = s64_t'(int_sqrt(sum));
			if (rad > 0) begin
				alpha = vector_angle(u, ady);
				beta = round_mul(alpha, isc, 28);
				rotate_unit(beta, sb, cb);
				r = clamp32(round_mul(rad, sc, 30));
				x1 = clamp32(round_mul(r, sb, 30));
				t = clamp32(round_mul(r, ONE30 - cb, 30));
				y1 = clamp32(rad + ap - round_mul(t, sc, 30));
				z1 = clamp32(round_mul(t, cc, 30));
				x2 = clamp32(clamp32(round_mul(x1, cr, 30)) - clamp32(round_mul(z1, sr, 30)));
				if (regs.spine_horizontal) begin
					res.out_x = y1[31:0];
					res.out_y = 32'(clamp32(sp + x2));
				end else begin
					res.out_x = 32'(clamp32(sp + x2));
					res.out_y = y1[31:0];
				end
			end
			return res;
		endfunction

		function void note_vertex(vertex_t vin);
			expected_q.push_back(deform(vin));
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h", $time, got.out_x, got.out_y);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			if (got.out_x !== exp_r.out_x) begin
				$display("%0t: out_x expected %h actual %h", $time, exp_r.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== exp_r.out_y) begin
				$display("%0t: out_y expected %h actual %h", $time, exp_r.out_y, got.out_y);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	vertex_t vertex;
	logic result_valid;
	result_t result;
	logic cfg_we;
	cfg_index_t cfg_index;
	logic [31:0] cfg_data;

	deform_scoreboard board;
	int idle_pct;
	int sent;

	cone_curl_vertex_deform u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.vertex(vertex),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_result(result);
	end

	task automatic write_cfg(cfg_index_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		board.write_reg(idx, d);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		vertex <= '{vertex_x: x, vertex_y: y};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_vertex('{vertex_x: x, vertex_y: y});
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.expected_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10)
			@(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
			2: return 32'($signed($urandom_range(2000)) - 1000);
			default: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
				: 32'h80000000 + $urandom_range(3);
		endcase
	endfunction

	task automatic random_config();
		write_cfg(REG_SPINE_HORIZONTAL, $urandom);
		write_cfg(REG_SPINE_POSITION, $urandom_range(1) ? rand_coord() : '0);
		write_cfg(REG_APEX_ALONG, rand_coord());
		write_cfg(REG_SINE_CONE_ANGLE, $urandom_range(1073741824));
		write_cfg(REG_COSINE_CONE_ANGLE, $urandom_range(1073741824));
		write_cfg(REG_INVERSE_SINE_CONE, $urandom_range(2147483647, 268435456));
		write_cfg(REG_SINE_ROTATION, 32'($signed($urandom_range(2147483648)) - 1073741824));
		write_cfg(REG_COSINE_ROTATION, 32'($signed($urandom_range(2147483648)) - 1073741824));
	endtask

	task automatic extreme_config(bit hi);
		write_cfg(REG_SPINE_HORIZONTAL, hi);
		write_cfg(REG_SPINE_POSITION, hi ? 32'h7FFFFFFF : 32'h80000000);
		write_cfg(REG_APEX_ALONG, hi ? 32'h80000000 : 32'h7FFFFFFF);
		write_cfg(REG_SINE_CONE_ANGLE, hi ? 32'h7FFFFFFF : 32'd0);
		write_cfg(REG_COSINE_CONE_ANGLE, hi ? 32'd1073741824 : 32'h7FFFFFFF);
		write_cfg(REG_INVERSE_SINE_CONE, hi ? 32'h7FFFFFFF : 32'd268435456);
		write_cfg(REG_SINE_ROTATION, hi ? 32'hC0000000 : 32'd1073741824);
		write_cfg(REG_COSINE_ROTATION, hi ? 32'd1073741824 : 32'hC0000000);
	endtask

	initial begin
		#20ms;
		$display("** cone_curl_vertex_deform: FAILED **");
		$finish;
	end

	initial begin
		board = new();
		board.reset_regs();
		arst_n = 1'b0;
		start = 1'b0;
		vertex = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SPINE_HORIZONTAL;
		cfg_data = '0;
		idle_pct = 0;
		sent = 0;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_vertex(32'd0, 32'd0);
		send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_vertex(32'h80000000, 32'h80000000);
		send_vertex(32'h7FFFFFFF, 32'h80000000);
		send_vertex(32'h00010000, 32'd0);
		send_vertex(32'hFFFF0000, 32'd0);
		send_vertex(32'd0, 32'hFFFF0000);
		send_vertex(32'd1, 32'd1);
		drain();
		write_cfg(REG_APEX_ALONG, 32'h00050000);
		write_cfg(REG_SPINE_POSITION, 32'hFFFD0000);
		send_vertex(32'hFFFD0000, 32'h00050000);
		send_vertex(32'hFFFD0001, 32'h00050000);
		drain();
		write_cfg(REG_SPINE_HORIZONTAL, 32'd1);
		send_vertex(32'h00050000, 32'hFFFD0000);
		send_vertex(32'h00020000, 32'h00010000);
		drain();
		extreme_config(1'b1);
		send_vertex(32'h80000000, 32'h80000000);
		send_vertex(32'h12345678, 32'h9ABCDEF0);
		send_vertex(32'h7FFFFFFF, 32'h00000000);
		drain();
		extreme_config(1'b0);
		send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF);
		send_vertex(32'h80000000, 32'h00001234);
		send_vertex(32'hFFFFFFFF, 32'h55555555);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 66;
				2: idle_pct = 18;
				default: idle_pct = 0;
			endcase
			if (ph == 0)
				board.reset_regs();
			random_config();
			for (int k = 0; k < 125; k++) begin
				if (k % 10 == 0)
					send_vertex(board.regs.spine_horizontal ? board.regs.apex_along
						: board.regs.spine_position,
						board.regs.spine_horizontal ? board.regs.spine_position
						: board.regs.apex_along);
				else
					send_vertex(rand_coord(), rand_coord());
			end
			drain();
		end

		$display("covered %0d vertices, %0d results checked, over 13 register settings",
			sent, board.checked);
		$display("idle phases 0/66/18 percent plus extreme and apex cases");
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("** cone_curl_vertex_deform: PASSED **");
		else
			$display("** cone_curl_vertex_deform: FAILED **");
		$finish;
	end
endmodule

// ===== sim.f =====
src/cvd_pkg.sv
src/cvd_root.sv
src/cvd_angle.sv
src/cvd_project.sv
src/cone_curl_vertex_deform.sv
tb/sv/tb_cone_curl_vertex_deform.sv
